// ----- design/mbdec_pkg.sv -----
// ----------------------------------------------------------------------------
// mbdec_pkg
// Shared types and constants of the macroblock decoder command port.
// ----------------------------------------------------------------------------
package mbdec_pkg;

  localparam int unsigned QUANT_TABLE_BYTES   = 64;
  localparam int unsigned SCALE_TABLE_ENTRIES = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned RX_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CMD   = 2'd0,
    OP_WRITE_CTRL  = 2'd1,
    OP_READ_DATA   = 2'd2,
    OP_READ_STATUS = 2'd3
  } op_t;

  // Command word bits 31:29; every other code is not a command.
  typedef enum logic [2:0] {
    CMD_DECODE = 3'd1,
    CMD_QUANT  = 3'd2,
    CMD_SCALE  = 3'd3
  } cmd_code_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic busy;
    logic begin_cmd;
    logic param;
    logic finish_decode;
    logic ctrl_write;
    logic warm_reset;
    logic drain;
    logic status_read;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_code_t new_code;
    logic      new_len_zero;
    logic      warm_req;
    logic      last_param;
    logic      code_is_decode;
    logic      pending_le1;
  } dp_stat_t;

endpackage

// ----- design/mbdec_req_if.sv -----
// ----------------------------------------------------------------------------
// mbdec_req_if
// Bus access channel: operation and written word.
// ----------------------------------------------------------------------------
interface mbdec_req_if;
  logic                               valid;
  logic                               ready;
  logic [mbdec_pkg::OP_W-1:0]         op;
  logic [mbdec_pkg::WORD_W-1:0]       wdata;

  modport source (output valid, output op, output wdata, input ready);
  modport sink   (input valid, input op, input wdata, output ready);
endinterface

// ----- design/mbdec_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mbdec_rsp_if
// Bus response channel: read word and phase after the access.
// ----------------------------------------------------------------------------
interface mbdec_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [mbdec_pkg::WORD_W-1:0]       rdata;
  logic [mbdec_pkg::PHASE_W-1:0]      phase;

  modport source (output valid, output rdata, output phase, input ready);
  modport sink   (input valid, input rdata, input phase, output ready);
endinterface

// ----- design/mbdec_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbdec_ctrl
// Phase state machine and handshake control; issues datapath commands.
// ----------------------------------------------------------------------------
module mbdec_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [mbdec_pkg::OP_W-1:0]    req_op,
  output logic                          req_ready,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [mbdec_pkg::PHASE_W-1:0] phase,
  input  mbdec_pkg::dp_stat_t           stat,
  output mbdec_pkg::dp_cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_PARAM     = 2'd1,
    ST_OUT_AVAIL = 2'd2,
    ST_DRAINED   = 2'd3
  } state_t;

  state_t state, state_next;
  logic   accept;

  // The response register frees up in the same cycle it is taken.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign phase     = state;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.busy   = (state == ST_PARAM);
    state_next = state;
    if (accept) begin
      case (mbdec_pkg::op_t'(req_op))
        mbdec_pkg::OP_WRITE_CMD: begin
          if (state == ST_PARAM) begin
            cmd.param = 1'b1;
            if (stat.last_param) begin
              cmd.finish_decode = stat.code_is_decode;
              state_next = stat.code_is_decode ? ST_OUT_AVAIL : ST_IDLE;
            end
          end else begin
            cmd.begin_cmd = 1'b1;
            case (stat.new_code)
              mbdec_pkg::CMD_DECODE: begin
                if (stat.new_len_zero) begin
                  cmd.finish_decode = 1'b1;
                  state_next = ST_OUT_AVAIL;
                end else begin
                  state_next = ST_PARAM;
                end
              end
              mbdec_pkg::CMD_QUANT,
              mbdec_pkg::CMD_SCALE: state_next = ST_PARAM;
              default:              state_next = ST_IDLE;
            endcase
          end
        end
        mbdec_pkg::OP_WRITE_CTRL: begin
          if (stat.warm_req) begin
            cmd.warm_reset = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.ctrl_write = 1'b1;
          end
        end
        mbdec_pkg::OP_READ_DATA: begin
          cmd.drain = 1'b1;
          if (stat.pending_le1 && state == ST_OUT_AVAIL) begin
            state_next = ST_DRAINED;
          end
        end
        mbdec_pkg::OP_READ_STATUS: cmd.status_read = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_accept_over_full: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!rsp_valid || rsp_ready))
    else $error("word accepted while response register is held");

  a_finish_to_avail: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_decode |=> state == ST_OUT_AVAIL)
    else $error("finished decode did not make output available");

  a_drained_from_avail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAINED && $past(state) != ST_DRAINED) |-> $past(state) == ST_OUT_AVAIL)
    else $error("drained phase entered from a phase other than output available");

endmodule

// ----- design/mbdec_dp.sv -----
// ----------------------------------------------------------------------------
// mbdec_dp
// Counters, status word, response data register and coefficient tables.
// ----------------------------------------------------------------------------
module mbdec_dp #(
  parameter int unsigned QUANT_TABLE_BYTES   = mbdec_pkg::QUANT_TABLE_BYTES,
  parameter int unsigned SCALE_TABLE_ENTRIES = mbdec_pkg::SCALE_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mbdec_pkg::WORD_W-1:0] wdata,
  input  mbdec_pkg::dp_cmd_t           cmd,
  output mbdec_pkg::dp_stat_t          stat,
  output logic [mbdec_pkg::WORD_W-1:0] rdata
);

  // Quant bytes are stored as one stream: luma first, then chroma.
  localparam int unsigned QUANT_BYTES = 2 * QUANT_TABLE_BYTES;
  localparam int unsigned QROWS       = (QUANT_BYTES + 3) / 4;
  localparam int unsigned QAW         = $clog2(QROWS);
  localparam int unsigned SROWS       = (SCALE_TABLE_ENTRIES + 1) / 2;
  localparam int unsigned SAW         = $clog2(SROWS);

  localparam logic [13:0] WORDS_CAP = 14'h2000;

  logic [15:0]                  words_remaining;
  logic [mbdec_pkg::RX_W-1:0]   words_received;
  mbdec_pkg::cmd_code_t         code;
  logic [13:0]                  decode_words;
  logic [13:0]                  pending;
  logic [1:0]                   output_depth;
  logic                         output_signed;
  logic                         output_set_bit15;
  logic                         dma_in_enable;
  logic                         dma_out_enable;
  logic [15:0]                  low_override;

  logic                         clear;
  logic [2:0]                   current_block;
  logic [mbdec_pkg::WORD_W-1:0] status_word;
  logic [13:0]                  new_words;
  logic                         quant_we;
  logic                         scale_we;

  logic [3:0][7:0]              quant_mem [QROWS];
  logic [1:0][15:0]             scale_mem [SROWS];
  logic [QROWS-1:0]             quant_vld;
  logic [SROWS-1:0]             scale_vld;

  function automatic logic [13:0] placeholder_words(input logic [15:0] len,
                                                    input logic [1:0]  depth);
    logic [16:0] n;
    logic [16:0] aligned;
    logic [18:0] words;
    logic [13:0] capped;
    logic [13:0] floor_w;
    n       = (len == 16'd0) ? 17'd1 : {1'b0, len};
    aligned = (n + 17'h1F) & ~17'h1F;
    words   = {aligned, 2'b00};
    capped  = (words > 19'(WORDS_CAP)) ? WORDS_CAP : words[13:0];
    case (depth)
      2'd0:    floor_w = 14'd8;
      2'd1:    floor_w = 14'd16;
      2'd2:    floor_w = 14'd192;
      default: floor_w = 14'd128;
    endcase
    return (capped > floor_w) ? capped : floor_w;
  endfunction

  assign clear         = rst || cmd.warm_reset;
  assign current_block = (output_depth <= 2'd1) ? 3'd4 : 3'd0;
  assign new_words     = placeholder_words(wdata[15:0], wdata[28:27]);

  assign stat.new_code       = mbdec_pkg::cmd_code_t'(wdata[31:29]);
  assign stat.new_len_zero   = (wdata[15:0] == 16'd0);
  assign stat.warm_req       = wdata[31];
  assign stat.last_param     = (words_remaining == 16'd1);
  assign stat.code_is_decode = (code == mbdec_pkg::CMD_DECODE);
  assign stat.pending_le1    = (pending <= 14'd1);

  always_comb begin
    status_word        = '0;
    status_word[31]    = (pending == 14'd0);
    status_word[30]    = cmd.busy && (words_remaining <= 16'd1);
    status_word[29]    = cmd.busy;
    status_word[28]    = dma_in_enable && cmd.busy;
    status_word[27]    = dma_out_enable && (pending != 14'd0);
    status_word[26:25] = output_depth;
    status_word[24]    = output_signed;
    status_word[23]    = output_set_bit15;
    status_word[18:16] = current_block;
    status_word[15:0]  = cmd.busy ? (words_remaining - 16'd1) : low_override;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      words_remaining  <= '0;
      words_received   <= '0;
      code             <= mbdec_pkg::CMD_DECODE;
      decode_words     <= '0;
      pending          <= '0;
      output_depth     <= '0;
      output_signed    <= 1'b0;
      output_set_bit15 <= 1'b0;
      dma_in_enable    <= 1'b0;
      dma_out_enable   <= 1'b0;
      low_override     <= rst ? 16'hFFFF : 16'h0000;
    end else begin
      if (cmd.begin_cmd) begin
        code             <= stat.new_code;
        words_received   <= '0;
        output_depth     <= wdata[28:27];
        output_signed    <= wdata[26];
        output_set_bit15 <= wdata[25];
        decode_words     <= new_words;
        pending          <= cmd.finish_decode ? new_words : 14'd0;
        case (stat.new_code)
          mbdec_pkg::CMD_DECODE: begin
            words_remaining <= wdata[15:0];
            low_override    <= 16'hFFFF;
          end
          mbdec_pkg::CMD_QUANT: begin
            words_remaining <= wdata[0] ? 16'd32 : 16'd16;
            low_override    <= 16'hFFFF;
          end
          mbdec_pkg::CMD_SCALE: begin
            words_remaining <= 16'd32;
            low_override    <= 16'hFFFF;
          end
          default: begin
            words_remaining <= '0;
            low_override    <= wdata[15:0];
          end
        endcase
      end
      if (cmd.param) begin
        words_received  <= words_received + 1'b1;
        words_remaining <= words_remaining - 16'd1;
        if (cmd.finish_decode) begin
          pending <= decode_words;
        end
      end
      if (cmd.ctrl_write) begin
        dma_in_enable  <= wdata[30];
        dma_out_enable <= wdata[29];
      end
      // Count down on data reads; hold at zero.
      if (cmd.drain && pending != 14'd0) begin
        pending <= pending - 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata <= cmd.status_read ? status_word : '0;
    end
  end

  assign quant_we = cmd.param && (code == mbdec_pkg::CMD_QUANT);
  assign scale_we = cmd.param && (code == mbdec_pkg::CMD_SCALE);

  // Table rows: byte and halfword enables drop anything past the table end.
  always_ff @(posedge clk) begin
    if (quant_we) begin
      for (int b = 0; b < 4; b++) begin
        if (32'({words_received, 2'(b)}) < QUANT_BYTES) begin
          quant_mem[QAW'(words_received)][b] <= wdata[8*b +: 8];
        end
      end
    end
    if (scale_we) begin
      for (int h = 0; h < 2; h++) begin
        if (32'({words_received, 1'(h)}) < SCALE_TABLE_ENTRIES) begin
          scale_mem[SAW'(words_received)][h] <= wdata[16*h +: 16];
        end
      end
    end
  end

  // Row valid bits: set when a table row is written, cleared by reset and warm reset.
  always_ff @(posedge clk) begin
    if (clear) begin
      quant_vld <= '0;
      scale_vld <= '0;
    end else begin
      if (quant_we && 32'(words_received) < QROWS) begin
        quant_vld[QAW'(words_received)] <= 1'b1;
      end
      if (scale_we && 32'(words_received) < SROWS) begin
        scale_vld[SAW'(words_received)] <= 1'b1;
      end
    end
  end

  a_busy_has_words: assert property (@(posedge clk) disable iff (rst)
    cmd.busy |-> words_remaining != 16'd0)
    else $error("parameter phase with no words remaining");

  a_no_output_while_busy: assert property (@(posedge clk) disable iff (rst)
    pending != 14'd0 |-> !cmd.busy)
    else $error("output words pending while awaiting parameters");

endmodule

// ----- design/macroblock_decoder_command_port.sv -----
// ----------------------------------------------------------------------------
// macroblock_decoder_command_port
// Register front end of a macroblock decoder: command, parameter and
// control writes, data and status reads.
// ----------------------------------------------------------------------------
// Response word: registered, valid in the cycle after its access is accepted.
// Throughput: one access per cycle; the single response register sets it, and
// a held response blocks the next access until it is taken.
// Reset: rst clears all control state and the table valid bits at once (no
// clearing pass); a bit-31 control write does so too but zeroes status[15:0].
module macroblock_decoder_command_port #(
  parameter int unsigned QUANT_TABLE_BYTES   = mbdec_pkg::QUANT_TABLE_BYTES,
  parameter int unsigned SCALE_TABLE_ENTRIES = mbdec_pkg::SCALE_TABLE_ENTRIES
) (
  input logic          clk,
  input logic          rst,
  mbdec_req_if.sink    bus_req,
  mbdec_rsp_if.source  bus_rsp
);

  mbdec_pkg::dp_cmd_t  cmd;
  mbdec_pkg::dp_stat_t stat;

  mbdec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (bus_req.valid),
    .req_op    (bus_req.op),
    .req_ready (bus_req.ready),
    .rsp_valid (bus_rsp.valid),
    .rsp_ready (bus_rsp.ready),
    .phase     (bus_rsp.phase),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbdec_dp #(
    .QUANT_TABLE_BYTES   (QUANT_TABLE_BYTES),
    .SCALE_TABLE_ENTRIES (SCALE_TABLE_ENTRIES)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .wdata (bus_req.wdata),
    .cmd   (cmd),
    .stat  (stat),
    .rdata (bus_rsp.rdata)
  );

endmodule

// ----- tb/mbdec_port_checker.sv -----
// ----------------------------------------------------------------------------
// mbdec_port_checker
// Watches the access and response channels of the command port, keeps its
// own copy of the port state, works out the response word of every accepted
// access and compares it field by field with what the port returns.
// ----------------------------------------------------------------------------
module mbdec_port_checker
  import mbdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mbdec_req_if        bus_req,
  mbdec_rsp_if        bus_rsp,
  output int unsigned fail_count,
  output int unsigned replies_owed
);

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 2'd0,
    PH_PARAMS    = 2'd1,
    PH_OUT_READY = 2'd2,
    PH_DRAINED   = 2'd3
  } port_phase_t;

  typedef struct {
    logic [WORD_W-1:0] rdata;
    port_phase_t       phase;
  } reply_t;

  localparam logic [31:0] OUT_WORDS_CAP    = 32'h2000;
  localparam logic [31:0] OUT_ALIGN_MASK   = 32'h1F;
  localparam logic [31:0] WORDS_PER_ROW    = 32'd4;
  localparam logic [15:0] QUANT_WORDS_LONG = 16'd32;
  localparam logic [15:0] QUANT_WORDS_SHORT = 16'd16;
  localparam logic [15:0] SCALE_WORDS      = 16'd32;
  localparam logic [15:0] LOW_ALL_ONES     = 16'hFFFF;
  localparam logic [2:0]  BLOCK_LUMA_FIRST = 3'd4;
  localparam logic [2:0]  BLOCK_FIRST      = 3'd0;
  localparam int unsigned DUE_DEPTH        = 4;

  // Table contents never reach the response, so they are not kept here.
  logic              busy;
  logic [15:0]       words_left;
  logic [2:0]        cmd_code;
  logic [15:0]       cmd_len;
  logic [13:0]       out_words;
  logic [1:0]        out_depth;
  logic              out_signed;
  logic              out_bit15;
  logic [2:0]        cur_block;
  logic              dma_in_en;
  logic              dma_out_en;
  logic              low_ovr_valid;
  logic [15:0]       low_ovr;
  port_phase_t       ph;
  reply_t            due_buf [DUE_DEPTH];
  int unsigned       due_head = 0;
  int unsigned       due_tail = 0;
  int unsigned       due_count = 0;
  int unsigned       fails = 0;

  function automatic logic [2:0] block_of(logic [1:0] depth);
    return (depth <= 2'd1) ? BLOCK_LUMA_FIRST : BLOCK_FIRST;
  endfunction

  function automatic logic [13:0] out_word_count(logic [15:0] len, logic [1:0] depth);
    logic [31:0] n;
    logic [31:0] words;
    logic [31:0] floor_words;
    n = (len == 16'd0) ? 32'd1 : 32'(len);
    words = ((n + OUT_ALIGN_MASK) & ~OUT_ALIGN_MASK) * WORDS_PER_ROW;
    if (words > OUT_WORDS_CAP) words = OUT_WORDS_CAP;
    case (depth)
      2'd0:    floor_words = 32'd8;
      2'd1:    floor_words = 32'd16;
      2'd2:    floor_words = 32'd192;
      default: floor_words = 32'd128;
    endcase
    if (words < floor_words) words = floor_words;
    return words[13:0];
  endfunction

  task automatic clear_state();
    busy          = 1'b0;
    words_left    = '0;
    cmd_code      = '0;
    cmd_len       = '0;
    out_words     = '0;
    out_depth     = '0;
    out_signed    = 1'b0;
    out_bit15     = 1'b0;
    cur_block     = BLOCK_LUMA_FIRST;
    dma_in_en     = 1'b0;
    dma_out_en    = 1'b0;
    low_ovr_valid = 1'b0;
    low_ovr       = LOW_ALL_ONES;
    ph            = PH_IDLE;
  endtask

  task automatic finish_cmd();
    if (cmd_code == CMD_DECODE) begin
      out_words = out_word_count(cmd_len, out_depth);
      cur_block = block_of(out_depth);
      ph = PH_OUT_READY;
    end
    busy = 1'b0;
    words_left = '0;
    if (ph != PH_OUT_READY) ph = PH_IDLE;
  endtask

  task automatic take_param();
    if (words_left != 0) words_left--;
    if (words_left == 0) finish_cmd();
  endtask

  task automatic start_cmd(logic [31:0] w);
    cmd_code      = w[31:29];
    cmd_len       = w[15:0];
    out_words     = '0;
    low_ovr_valid = 1'b0;
    out_depth     = w[28:27];
    out_signed    = w[26];
    out_bit15     = w[25];
    cur_block     = block_of(out_depth);
    case (cmd_code)
      CMD_DECODE: begin
        busy = 1'b1;
        words_left = w[15:0];
        if (words_left == 0) finish_cmd();
        else ph = PH_PARAMS;
      end
      CMD_QUANT: begin
        busy = 1'b1;
        words_left = w[0] ? QUANT_WORDS_LONG : QUANT_WORDS_SHORT;
        ph = PH_PARAMS;
      end
      CMD_SCALE: begin
        busy = 1'b1;
        words_left = SCALE_WORDS;
        ph = PH_PARAMS;
      end
      default: begin
        // not a command: no parameters follow; the status low half takes the word's low half
        busy = 1'b0;
        words_left = '0;
        ph = PH_IDLE;
        low_ovr_valid = 1'b1;
        low_ovr = w[15:0];
      end
    endcase
  endtask

  function automatic logic [31:0] status_now();
    logic [31:0] s;
    logic        has_out;
    s = '0;
    has_out = (out_words != 0);
    s[31]    = !has_out;
    s[30]    = busy && (words_left <= 16'd1);
    s[29]    = busy;
    s[28]    = dma_in_en && busy && (words_left != 0);
    s[27]    = dma_out_en && has_out;
    s[26:25] = out_depth;
    s[24]    = out_signed;
    s[23]    = out_bit15;
    s[18:16] = cur_block;
    if (busy && words_left != 0) s[15:0] = words_left - 16'd1;
    else if (low_ovr_valid) s[15:0] = low_ovr;
    else s[15:0] = LOW_ALL_ONES;
    return s;
  endfunction

  task automatic run_access(input op_t op, input logic [31:0] w, output reply_t r);
    r.rdata = '0;
    case (op)
      OP_WRITE_CMD: begin
        if (busy) take_param();
        else start_cmd(w);
      end
      OP_WRITE_CTRL: begin
        if (w[31]) begin
          clear_state();
          low_ovr_valid = 1'b1;
          low_ovr = '0;
        end else begin
          dma_in_en  = w[30];
          dma_out_en = w[29];
        end
      end
      OP_READ_DATA: begin
        if (out_words != 0) out_words--;
        if (out_words == 0) begin
          cur_block = block_of(out_depth);
          if (ph == PH_OUT_READY) ph = PH_DRAINED;
        end
      end
      default: r.rdata = status_now();
    endcase
    r.phase = ph;
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t made;
    if (rst) begin
      clear_state();
      due_head  = 0;
      due_tail  = 0;
      due_count = 0;
    end else begin
      // a response at this edge belongs to an access taken at an earlier edge
      if (bus_rsp.valid && bus_rsp.ready) begin
        if (due_count == 0) begin
          fails++;
          $error("response word with no access outstanding: rdata %h phase %0d",
                 bus_rsp.rdata, bus_rsp.phase);
        end else begin
          want = due_buf[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_count--;
          if (bus_rsp.rdata !== want.rdata) begin
            fails++;
            $error("rdata: expected %h, got %h", want.rdata, bus_rsp.rdata);
          end
          if (bus_rsp.phase !== want.phase) begin
            fails++;
            $error("phase: expected %0d, got %0d", want.phase, bus_rsp.phase);
          end
        end
      end
      if (bus_req.valid && bus_req.ready) begin
        run_access(op_t'(bus_req.op), bus_req.wdata, made);
        if (due_count == DUE_DEPTH) begin
          fails++;
          $error("accesses outstanding: expected at most %0d, got %0d",
                 DUE_DEPTH, due_count + 1);
        end else begin
          due_buf[due_tail] = made;
          due_tail = (due_tail + 1) % DUE_DEPTH;
          due_count++;
        end
      end
    end
    fail_count   <= fails;
    replies_owed <= due_count;
  end

endmodule

// ----- tb/tb_macroblock_decoder_command_port.sv -----
// ----------------------------------------------------------------------------
// tb_macroblock_decoder_command_port
// Drives bus accesses into the command port: a directed opening, one short
// decode read out to the drained phase, then random command sequences under
// several mixes of sender gaps and response stalls. The checker beside the
// port judges every response word.
// ----------------------------------------------------------------------------
module tb_macroblock_decoder_command_port;
  import mbdec_pkg::*;

  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned ITEMS_PER_STAGE = 50;
  localparam int unsigned SHORT_DRAIN     = 128;

  localparam logic [31:0] CTRL_WARM_RESET = 32'h8000_0000;
  localparam logic [31:0] CTRL_DMA_IN     = 32'h4000_0000;
  localparam logic [31:0] CTRL_DMA_BOTH   = 32'h6000_0000;
  localparam logic [2:0]  CODE_NONE_ZERO  = 3'd0;
  localparam logic [2:0]  CODE_NONE_HIGH  = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned fail_count;
  int unsigned replies_owed;

  mbdec_req_if bus_req();
  mbdec_rsp_if bus_rsp();

  macroblock_decoder_command_port DUT (
    .clk     (clk),
    .rst     (rst),
    .bus_req (bus_req),
    .bus_rsp (bus_rsp)
  );

  mbdec_port_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .bus_req      (bus_req),
    .bus_rsp      (bus_rsp),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    bus_rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (bus_req.valid && bus_req.ready) || (bus_rsp.valid && bus_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("** macroblock_decoder_command_port: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_word(input op_t op, input logic [31:0] w);
    while ($urandom_range(99) < gap_pct) begin
      bus_req.valid <= 1'b0;
      @(posedge clk);
    end
    bus_req.valid <= 1'b1;
    bus_req.op    <= op;
    bus_req.wdata <= w;
    @(posedge clk);
    while (!bus_req.ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [31:0] cmd_word(logic [2:0] code, logic [15:0] len);
    logic [31:0] w;
    w = $urandom;
    w[31:29] = code;
    w[15:0] = len;
    return w;
  endfunction

  // accesses that leave a running parameter stream alone
  task automatic put_aside();
    case ($urandom_range(2))
      0:       put_word(OP_READ_STATUS, $urandom);
      1:       put_word(OP_READ_DATA, $urandom);
      default: put_word(OP_WRITE_CTRL, {1'b0, 31'($urandom)});
    endcase
  endtask

  task automatic put_params(int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) put_aside();
      put_word(OP_WRITE_CMD, $urandom);
    end
  endtask

  task automatic put_reads(int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(15) == 0) put_word(OP_READ_STATUS, $urandom);
      put_word(OP_READ_DATA, $urandom);
    end
    put_word(OP_READ_STATUS, $urandom);
  endtask

  task automatic run_sequence();
    logic [31:0] w;
    logic [15:0] len;
    logic [2:0]  code;
    case ($urandom_range(9))
      0, 1, 2: begin
        len = ($urandom_range(7) == 0) ? 16'($urandom_range(33, 70))
                                       : 16'($urandom_range(0, 32));
        put_word(OP_WRITE_CMD, cmd_word(CMD_DECODE, len));
        put_params(len);
        put_reads($urandom_range(4));
      end
      3: begin
        w = cmd_word(CMD_QUANT, 16'($urandom));
        put_word(OP_WRITE_CMD, w);
        put_params(w[0] ? 32 : 16);
        put_word(OP_READ_STATUS, $urandom);
      end
      4: begin
        put_word(OP_WRITE_CMD, cmd_word(CMD_SCALE, 16'($urandom)));
        put_params(32);
        put_word(OP_READ_STATUS, $urandom);
      end
      5: begin
        code = 3'($urandom_range(4, 8));
        if (code == 3'd0) code = CODE_NONE_ZERO;
        put_word(OP_WRITE_CMD, cmd_word((code > CODE_NONE_HIGH) ? CODE_NONE_ZERO : code,
                                        16'($urandom)));
        put_word(OP_READ_STATUS, $urandom);
      end
      6: begin
        w = $urandom;
        w[31] = ($urandom_range(7) == 0);
        put_word(OP_WRITE_CTRL, w);
        put_word(OP_READ_STATUS, $urandom);
      end
      7: begin
        // start a command, send it up to five parameters and end with a warm reset
        case ($urandom_range(2))
          0:       put_word(OP_WRITE_CMD, cmd_word(CMD_DECODE, 16'($urandom_range(1, 16'hFFFF))));
          1:       put_word(OP_WRITE_CMD, cmd_word(CMD_QUANT, 16'($urandom)));
          default: put_word(OP_WRITE_CMD, cmd_word(CMD_SCALE, 16'($urandom)));
        endcase
        put_params($urandom_range(5));
        put_word(OP_READ_STATUS, $urandom);
        put_word(OP_WRITE_CTRL, CTRL_WARM_RESET | 32'($urandom_range(0, 32'h7FFF_FFFF)));
      end
      8: begin
        repeat ($urandom_range(1, 3)) put_word(op_t'($urandom_range(3)), $urandom);
      end
      default: begin
        put_word($urandom_range(1) ? OP_READ_STATUS : OP_READ_DATA, $urandom);
      end
    endcase
  endtask

  initial begin
    int unsigned stage;
    int unsigned mark;
    rst           <= 1'b1;
    bus_req.valid <= 1'b0;
    bus_req.op    <= OP_READ_STATUS;
    bus_req.wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    put_word(OP_READ_STATUS, 32'hFFFF_FFFF);
    put_word(OP_READ_DATA, 32'h0000_0000);
    put_word(OP_WRITE_CTRL, CTRL_DMA_BOTH);
    put_word(OP_WRITE_CMD, 32'h0000_ABCD);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CMD, 32'h2000_0000);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_READ_DATA, 32'hFFFF_FFFF);
    put_word(OP_WRITE_CMD, 32'hE000_1234);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CMD, 32'h3E00_0002);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CMD, 32'hFFFF_FFFF);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CMD, 32'h0000_0000);
    put_word(OP_WRITE_CTRL, CTRL_WARM_RESET);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CMD, 32'h4000_0001);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CTRL, CTRL_DMA_IN);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CTRL, 32'hFFFF_FFFF);
    put_word(OP_WRITE_CMD, 32'h6000_0000);
    put_word(OP_READ_STATUS, 32'h0000_0000);
    put_word(OP_WRITE_CTRL, CTRL_WARM_RESET);

    // decode with no parameters: read every output word, then one more
    put_word(OP_WRITE_CMD, 32'h2000_0000);
    put_reads(SHORT_DRAIN + 1);

    for (stage = 0; stage < 4; stage++) begin
      case (stage)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 85; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 85; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      mark = n_sent;
      while (n_sent - mark < ITEMS_PER_STAGE) run_sequence();
    end

    bus_req.valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** macroblock_decoder_command_port: PASSED **");
    end else begin
      $display("** macroblock_decoder_command_port: FAILED **");
    end
    $finish;
  end

endmodule
